[rtl/mf3_pkg.sv]
// ----------------------------------------------------------------------------
// mf3_pkg: shared types, constants and sort helpers
// Widths, the queue item format and the odd-even transposition sort rounds
// used by the 3x3 RGB median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int CNT_W       = COL_W + 1;
    localparam int WREG_W      = 11;
    localparam int HREG_W      = 16;
    localparam int ROW_W       = HREG_W + 1;
    localparam int PIX_W       = 24;
    localparam int CH_W        = 8;
    localparam int CH_N        = 3;
    localparam int WIN_N       = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int FIRST_ROUNDS  = 5;
    localparam int SECOND_ROUNDS = WIN_N - FIRST_ROUNDS;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

    localparam logic [WREG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [HREG_W-1:0] HEIGHT_RESET = 16'd480;

    typedef logic [CH_W-1:0] chan_t;
    typedef chan_t [WIN_N-1:0] win_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pixel;
        logic             emit;
        logic             last;
        logic [WIN_N-1:0] valid_mask;
        logic [WIN_N-1:0] pad_high;
        logic             odd;
    } item_t;

    function automatic win_t sort_round(win_t v, logic parity);
        win_t  r;
        chan_t a;
        chan_t b;
        r = v;
        for (int i = 0; i < WIN_N - 1; i++) begin
            if (1'(i % 2) == parity) begin
                a = r[i];
                b = r[i+1];
                if (a > b) begin
                    r[i]   = b;
                    r[i+1] = a;
                end
            end
        end
        return r;
    endfunction

    function automatic win_t sort_rounds(win_t v, int first, int count);
        win_t r;
        r = v;
        for (int k = 0; k < count; k++) begin
            r = sort_round(r, 1'((first + k) % 2));
        end
        return r;
    endfunction

endpackage

[rtl/median_filter_3x3_rgb.sv]
// ----------------------------------------------------------------------------
// median_filter_3x3_rgb: streaming 3x3 median filter for RGB pixels
// Raster-order pixels in, per-channel neighborhood medians out, with two
// line stores and a front part decoupled from the sort pipeline by a queue.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Payload
//  in        in_valid / in_ready     action, red_in, green_in, blue_in
//  out       out_valid / out_ready   red_out, green_out, blue_out, frame_end
//  cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One transaction per clock is sustained on both sides. A result passes the
// queue, line store read, window capture, two sort halves and the output
// register in turn. Results follow input by image_width+1 transactions.
// Reset clears counters and the window; the line stores need no clearing. A
// stalled output holds the whole back pipeline, and input stalls only once
// the four-entry queue is full.
module median_filter_3x3_rgb (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           action,
    input  logic [mf3_pkg::CH_W-1:0]       red_in,
    input  logic [mf3_pkg::CH_W-1:0]       green_in,
    input  logic [mf3_pkg::CH_W-1:0]       blue_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [mf3_pkg::CH_W-1:0]       red_out,
    output logic [mf3_pkg::CH_W-1:0]       green_out,
    output logic [mf3_pkg::CH_W-1:0]       blue_out,
    output logic                           frame_end,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mf3_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic           queue_full;
    logic           queue_empty;
    logic           push;
    logic           pop;
    mf3_pkg::item_t push_item;
    mf3_pkg::item_t head;

    mf3_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    mf3_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (queue_full),
        .empty     (queue_empty),
        .head      (head)
    );

    mf3_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (queue_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .frame_end (frame_end)
    );

endmodule

[rtl/mf3_front.sv]
// ----------------------------------------------------------------------------
// mf3_front: input acceptance and classification
// Holds the frame registers and position counters, drops drain ticks that
// arrive mid-frame, and builds one queue item per pixel position.
// ----------------------------------------------------------------------------
module mf3_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              action,
    input  logic [mf3_pkg::CH_W-1:0]          red_in,
    input  logic [mf3_pkg::CH_W-1:0]          green_in,
    input  logic [mf3_pkg::CH_W-1:0]          blue_in,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              queue_full,
    output logic                              push,
    output mf3_pkg::item_t                    push_item
);

    logic [mf3_pkg::WREG_W-1:0] width_reg;
    logic [mf3_pkg::HREG_W-1:0] height_reg;
    logic [mf3_pkg::COL_W-1:0]  in_col_reg, in_col_next;
    logic [mf3_pkg::ROW_W-1:0]  in_row_reg, in_row_next;
    logic [mf3_pkg::COL_W-1:0]  out_col_reg, out_col_next;
    logic [mf3_pkg::HREG_W-1:0] out_row_reg, out_row_next;

    logic [mf3_pkg::CNT_W-1:0]  w;
    logic [mf3_pkg::HREG_W-1:0] h;
    logic [mf3_pkg::COL_W-1:0]  ic;
    logic [mf3_pkg::CNT_W-1:0]  col_inc;
    logic [mf3_pkg::CNT_W-1:0]  out_col_inc;
    logic [mf3_pkg::ROW_W-1:0]  out_row_inc;
    logic                       input_done;
    logic                       ignore;
    logic                       emit;
    logic                       last;
    logic                       take;
    logic [2:0]                 row_ok;
    logic [2:0]                 col_ok;
    logic [mf3_pkg::WIN_N-1:0]  mask;
    logic [mf3_pkg::WIN_N-1:0]  pad;
    logic                       toggle;

    assign cfg_ready = 1'b1;
    assign in_ready  = !queue_full;
    assign take      = in_valid && in_ready;

    always_comb
    begin
        if (width_reg == '0) begin
            w = mf3_pkg::CNT_W'(1);
        end else if (32'(width_reg) > 32'(mf3_pkg::MAX_WIDTH)) begin
            w = mf3_pkg::CNT_W'(mf3_pkg::MAX_WIDTH);
        end else begin
            w = mf3_pkg::CNT_W'(width_reg);
        end
        h = (height_reg == '0) ? mf3_pkg::HREG_W'(1) : height_reg;

        if ({1'b0, in_col_reg} >= w) begin
            ic = mf3_pkg::COL_W'(w - mf3_pkg::CNT_W'(1));
        end else begin
            ic = in_col_reg;
        end
        col_inc     = {1'b0, ic} + mf3_pkg::CNT_W'(1);
        out_col_inc = {1'b0, out_col_reg} + mf3_pkg::CNT_W'(1);
        out_row_inc = {1'b0, out_row_reg} + mf3_pkg::ROW_W'(1);

        input_done = in_row_reg >= {1'b0, h};
        ignore     = !input_done && action;
        emit       = (in_row_reg >= mf3_pkg::ROW_W'(2))
                     || ((in_row_reg == mf3_pkg::ROW_W'(1)) && (ic != '0));
        last       = (out_row_inc >= {1'b0, h}) && (out_col_inc >= w);

        row_ok = {out_row_inc < {1'b0, h}, 1'b1, out_row_reg != '0};
        col_ok = {out_col_inc < w, 1'b1, out_col_reg != '0};
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                mask[3*r + c] = row_ok[r] && col_ok[c];
            end
        end
        toggle = 1'b1;
        for (int k = 0; k < mf3_pkg::WIN_N; k++) begin
            pad[k] = 1'b0;
            if (!mask[k]) begin
                pad[k] = toggle;
                toggle = !toggle;
            end
        end

        push_item.col        = ic;
        push_item.pixel      = input_done ? '0 : {red_in, green_in, blue_in};
        push_item.emit       = emit;
        push_item.last       = last;
        push_item.valid_mask = mask;
        push_item.pad_high   = pad;
        push_item.odd        = ^mask;
        push = take && !ignore;

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (push) begin
            if (col_inc >= w) begin
                in_col_next = '0;
                in_row_next = in_row_reg + mf3_pkg::ROW_W'(1);
            end else begin
                in_col_next = mf3_pkg::COL_W'(col_inc);
            end
            if (emit) begin
                if (last) begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end else if (out_col_inc >= w) begin
                    out_col_next = '0;
                    out_row_next = mf3_pkg::HREG_W'(out_row_inc);
                end else begin
                    out_col_next = mf3_pkg::COL_W'(out_col_inc);
                end
            end
        end
        if (cfg_valid && cfg_ready) begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            width_reg   <= mf3_pkg::WIDTH_RESET;
            height_reg  <= mf3_pkg::HEIGHT_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    mf3_pkg::CFG_WIDTH:  width_reg  <= cfg_data[mf3_pkg::WREG_W-1:0];
                    mf3_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

endmodule

[rtl/mf3_queue.sv]
// ----------------------------------------------------------------------------
// mf3_queue: short item queue
// Four-entry first-in first-out store between the front and back parts.
// ----------------------------------------------------------------------------
module mf3_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mf3_pkg::item_t push_item,
    input  logic           pop,
    output logic           full,
    output logic           empty,
    output mf3_pkg::item_t head
);

    mf3_pkg::item_t                entry_reg [mf3_pkg::QUEUE_DEPTH];
    logic [mf3_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [mf3_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [mf3_pkg::QPTR_W:0]      count_reg, count_next;

    assign full  = count_reg == (mf3_pkg::QPTR_W+1)'(mf3_pkg::QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

[rtl/mf3_back.sv]
// ----------------------------------------------------------------------------
// mf3_back: line stores, window and median pipeline
// Reads and updates the two line stores, shifts the 3x3 window and sorts
// each channel in two pipelined halves before the output register.
// ----------------------------------------------------------------------------
module mf3_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     empty,
    input  mf3_pkg::item_t           head,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [mf3_pkg::CH_W-1:0] red_out,
    output logic [mf3_pkg::CH_W-1:0] green_out,
    output logic [mf3_pkg::CH_W-1:0] blue_out,
    output logic                     frame_end
);

    logic [mf3_pkg::PIX_W-1:0] upper_mem [mf3_pkg::MAX_WIDTH];
    logic [mf3_pkg::PIX_W-1:0] lower_mem [mf3_pkg::MAX_WIDTH];

    logic                      adv;
    logic                      s1_valid_reg;
    mf3_pkg::item_t            s1_item_reg;
    logic [mf3_pkg::PIX_W-1:0] upper_rd_reg, lower_rd_reg;
    logic                      byp_reg;
    logic [mf3_pkg::PIX_W-1:0] byp_upper_reg, byp_lower_reg;
    logic [mf3_pkg::PIX_W-1:0] above2, above1;
    logic [mf3_pkg::PIX_W-1:0] col_a_reg [3];
    logic [mf3_pkg::PIX_W-1:0] col_b_reg [3];
    logic [mf3_pkg::PIX_W-1:0] new_col [3];
    mf3_pkg::win_t             s2_next [mf3_pkg::CH_N];

    logic                      s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic                      s2_odd_reg, s3_odd_reg, s4_odd_reg;
    logic                      s2_last_reg, s3_last_reg, s4_last_reg, out_last_reg;
    mf3_pkg::win_t             s2_win_reg [mf3_pkg::CH_N];
    mf3_pkg::win_t             s3_win_reg [mf3_pkg::CH_N];
    mf3_pkg::win_t             s4_win_reg [mf3_pkg::CH_N];
    logic [mf3_pkg::CH_W-1:0]  res_next [mf3_pkg::CH_N];
    logic [mf3_pkg::CH_W-1:0]  res_reg [mf3_pkg::CH_N];
    logic [mf3_pkg::CH_W:0]    mid_sum;
    logic [mf3_pkg::PIX_W-1:0] px;

    assign adv = !out_valid_reg || out_ready;
    assign pop = adv && !empty;

    assign out_valid = out_valid_reg;
    assign frame_end = out_last_reg;
    assign red_out   = res_reg[0];
    assign green_out = res_reg[1];
    assign blue_out  = res_reg[2];

    always_comb
    begin
        above2 = byp_reg ? byp_upper_reg : upper_rd_reg;
        above1 = byp_reg ? byp_lower_reg : lower_rd_reg;
        new_col[0] = above2;
        new_col[1] = above1;
        new_col[2] = s1_item_reg.pixel;

        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                case (c)
                    0:       px = col_a_reg[r];
                    1:       px = col_b_reg[r];
                    default: px = new_col[r];
                endcase
                for (int ch = 0; ch < mf3_pkg::CH_N; ch++) begin
                    if (s1_item_reg.valid_mask[3*r + c]) begin
                        s2_next[ch][3*r + c] = px[mf3_pkg::PIX_W-1-mf3_pkg::CH_W*ch -: mf3_pkg::CH_W];
                    end else begin
                        s2_next[ch][3*r + c] = {mf3_pkg::CH_W{s1_item_reg.pad_high[3*r + c]}};
                    end
                end
            end
        end

        for (int ch = 0; ch < mf3_pkg::CH_N; ch++) begin
            mid_sum = {1'b0, s4_win_reg[ch][3]} + {1'b0, s4_win_reg[ch][4]};
            res_next[ch] = s4_odd_reg ? s4_win_reg[ch][4] : mid_sum[mf3_pkg::CH_W:1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            upper_rd_reg  <= upper_mem[head.col];
            lower_rd_reg  <= lower_mem[head.col];
            s1_item_reg   <= head;
            byp_upper_reg <= above1;
            byp_lower_reg <= s1_item_reg.pixel;
        end
        if (adv && s1_valid_reg) begin
            upper_mem[s1_item_reg.col] <= above1;
            lower_mem[s1_item_reg.col] <= s1_item_reg.pixel;
        end
        if (adv) begin
            s2_odd_reg  <= s1_item_reg.odd;
            s2_last_reg <= s1_item_reg.last;
            s3_odd_reg  <= s2_odd_reg;
            s3_last_reg <= s2_last_reg;
            s4_odd_reg  <= s3_odd_reg;
            s4_last_reg <= s3_last_reg;
            for (int ch = 0; ch < mf3_pkg::CH_N; ch++) begin
                s2_win_reg[ch] <= s2_next[ch];
                s3_win_reg[ch] <= mf3_pkg::sort_rounds(s2_win_reg[ch], 0,
                                                       mf3_pkg::FIRST_ROUNDS);
                s4_win_reg[ch] <= mf3_pkg::sort_rounds(s3_win_reg[ch],
                                                       mf3_pkg::FIRST_ROUNDS,
                                                       mf3_pkg::SECOND_ROUNDS);
                res_reg[ch]    <= res_next[ch];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            byp_reg       <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                col_a_reg[r] <= '0;
                col_b_reg[r] <= '0;
            end
        end else begin
            if (pop) begin
                byp_reg <= s1_valid_reg && (s1_item_reg.col == head.col);
            end
            if (adv) begin
                s1_valid_reg  <= pop;
                s2_valid_reg  <= s1_valid_reg && s1_item_reg.emit;
                s3_valid_reg  <= s2_valid_reg;
                s4_valid_reg  <= s3_valid_reg;
                out_valid_reg <= s4_valid_reg;
                out_last_reg  <= s4_last_reg;
                if (s1_valid_reg) begin
                    for (int r = 0; r < 3; r++) begin
                        col_a_reg[r] <= col_b_reg[r];
                        col_b_reg[r] <= new_col[r];
                    end
                end
            end
        end
    end

endmodule

[verif/median_filter_3x3_rgb_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_3x3_rgb_tb: self-checking bench for the 3x3 RGB median filter
// Drives raster frames of several sizes through the pixel channel, predicts
// each per-channel neighborhood median and frame end flag, and compares every
// output transaction with the oldest prediction under varied idling.
// ----------------------------------------------------------------------------
module median_filter_3x3_rgb_tb;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;
    localparam int   SETTLE    = 20;
    localparam int   WATCHDOG  = 5000;
    localparam int   HOLD_LEN  = 300;

    typedef struct {
        logic       act;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_item_t;

    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       fe;
    } median_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic action = ACT_PIXEL;
    logic [7:0] red_in = '0;
    logic [7:0] green_in = '0;
    logic [7:0] blue_in = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic frame_end;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index = mf3_pkg::CFG_WIDTH;
    logic [mf3_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    pixel_item_t    pixel_q[$];
    median_result_t median_q[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_go = 1'b0;
    int hold_cnt = 0;
    bit in_taken = 1'b0;
    int quiet_cycles = 0;
    int queued = 0;

    logic [23:0] upper_row[mf3_pkg::MAX_WIDTH];
    logic [23:0] lower_row[mf3_pkg::MAX_WIDTH];
    logic [23:0] win[3][3];
    int unsigned in_col, in_row, out_col, out_row;
    logic [10:0] width_reg = mf3_pkg::WIDTH_RESET;
    logic [15:0] height_reg = mf3_pkg::HEIGHT_RESET;

    median_filter_3x3_rgb dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > mf3_pkg::MAX_WIDTH) return mf3_pkg::MAX_WIDTH;
        return 32'(width_reg);
    endfunction

    function automatic int unsigned eff_height();
        return (height_reg == 0) ? 1 : 32'(height_reg);
    endfunction

    function automatic logic [7:0] median_of(logic [7:0] v[9], int n);
        logic [7:0] t;
        int j;
        for (int i = 1; i < n; i++) begin
            t = v[i];
            j = i;
            while (j > 0 && v[j-1] > t) begin
                v[j] = v[j-1];
                j--;
            end
            v[j] = t;
        end
        if (n % 2 == 1) return v[n/2];
        return 8'((int'(v[n/2]) + int'(v[n/2-1])) >> 1);
    endfunction

    function automatic median_result_t window_median(int colbase, int unsigned w,
                                                     int unsigned h);
        median_result_t res;
        logic [7:0] rv[9];
        logic [7:0] gv[9];
        logic [7:0] bv[9];
        int n;
        int r;
        int c;
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                r = int'(out_row) + dr;
                c = int'(out_col) + dc;
                if (r >= 0 && c >= 0 && r < int'(h) && c < int'(w)
                    && dc + colbase >= 0 && dc + colbase <= 2) begin
                    {rv[n], gv[n], bv[n]} = win[dc+colbase][dr+1];
                    n++;
                end
            end
        end
        res.r = (n > 0) ? median_of(rv, n) : 8'd0;
        res.g = (n > 0) ? median_of(gv, n) : 8'd0;
        res.b = (n > 0) ? median_of(bv, n) : 8'd0;
        res.fe = 1'b0;
        return res;
    endfunction

    task automatic shift_column(logic [23:0] top, logic [23:0] mid, logic [23:0] bot);
        win[0] = win[1];
        win[1] = win[2];
        win[2][0] = top;
        win[2][1] = mid;
        win[2][2] = bot;
    endtask

    task automatic restart_counters();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endtask

    task automatic filter_pixel(pixel_item_t it);
        int unsigned w;
        int unsigned h;
        int unsigned ic;
        bit done;
        bit emit;
        logic [23:0] cur;
        logic [23:0] a2;
        logic [23:0] a1;
        median_result_t res;
        w = eff_width();
        h = eff_height();
        done = in_row >= h;
        if (!done && it.act == ACT_DRAIN) return;
        cur = done ? 24'd0 : {it.r, it.g, it.b};
        ic = (in_col >= w) ? w - 1 : in_col;
        emit = longint'(in_row) * w + ic >= longint'(w) + 1;
        a2 = upper_row[ic];
        a1 = lower_row[ic];
        upper_row[ic] = a1;
        lower_row[ic] = cur;
        if (ic != 0) begin
            shift_column(a2, a1, cur);
            if (emit) res = window_median(1, w, h);
        end
        else begin
            if (emit) res = window_median(2, w, h);
            shift_column(a2, a1, cur);
        end
        in_col = ic + 1;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (!emit) return;
        if (out_row + 1 >= h && out_col + 1 >= w) begin
            res.fe = 1'b1;
            restart_counters();
        end
        else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
        median_q = {median_q, res};
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Prediction on accepted input, checking on accepted output.
    always @(posedge clk)
    begin
        median_result_t want;
        pixel_item_t it;
        if (rst_n) begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready) begin
                it.act = action;
                it.r = red_in;
                it.g = green_in;
                it.b = blue_in;
                filter_pixel(it);
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == mf3_pkg::CFG_WIDTH) width_reg = cfg_data[10:0];
                else height_reg = cfg_data;
                restart_counters();
            end
            if (out_valid && out_ready) begin
                if (median_q.size() == 0) begin
                    report("unexpected transaction", int'(red_out), -1);
                end
                else begin
                    want = median_q.pop_front();
                    if (red_out !== want.r)
                        report("red_out", int'(red_out), int'(want.r));
                    if (green_out !== want.g)
                        report("green_out", int'(green_out), int'(want.g));
                    if (blue_out !== want.b)
                        report("blue_out", int'(blue_out), int'(want.b));
                    if (frame_end !== want.fe)
                        report("frame_end", int'(frame_end), int'(want.fe));
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Pixel driver.
    always @(negedge clk)
    begin
        pixel_item_t it;
        if (rst_n && (!in_valid || in_taken)) begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                it = pixel_q.pop_front();
                action <= it.act;
                red_in <= it.r;
                green_in <= it.g;
                blue_in <= it.b;
                in_valid <= 1'b1;
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver, with one long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_go && hold_cnt < HOLD_LEN) begin
            hold_cnt <= hold_cnt + 1;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic add_pixel(logic act, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        pixel_item_t it;
        it.act = act;
        it.r = r;
        it.g = g;
        it.b = b;
        pixel_q = {pixel_q, it};
        queued++;
    endtask

    task automatic add_random_pixel();
        add_pixel(ACT_PIXEL, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
    endtask

    task automatic wait_idle();
        wait (pixel_q.size() == 0 && !in_valid && median_q.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [mf3_pkg::CFG_IDX_W-1:0] idx,
                             logic [mf3_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(int w, int h);
        wait_idle();
        write_reg(mf3_pkg::CFG_WIDTH, 16'(w));
        write_reg(mf3_pkg::CFG_HEIGHT, 16'(h));
    endtask

    // Full frame with stray drain ticks, then the flush.
    task automatic add_frame(int unsigned w, int unsigned h);
        for (int unsigned i = 0; i < w * h; i++) begin
            if ($urandom_range(9) == 0) add_pixel(ACT_DRAIN, 8'hFF, 8'h00, 8'hAA);
            add_random_pixel();
        end
        for (int unsigned i = 0; i <= w; i++) begin
            if ($urandom_range(3) == 0) add_random_pixel();
            else add_pixel(ACT_DRAIN, 8'($urandom_range(255)), 8'h00, 8'h00);
        end
    endtask

    initial
    begin
        int w;
        int h;
        int phase;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: degenerate sizes, extremes of the channels, drains.
        set_frame(0, 0);
        add_pixel(ACT_DRAIN, 8'h00, 8'h00, 8'h00);
        add_pixel(ACT_PIXEL, 8'hFF, 8'h00, 8'h55);
        add_pixel(ACT_PIXEL, 8'h00, 8'hFF, 8'hAA);
        add_pixel(ACT_PIXEL, 8'h12, 8'h34, 8'h56);
        set_frame(3, 3);
        add_pixel(ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        add_pixel(ACT_DRAIN, 8'h00, 8'h00, 8'h00);
        add_pixel(ACT_PIXEL, 8'h00, 8'h00, 8'h00);
        add_pixel(ACT_PIXEL, 8'hFF, 8'h01, 8'h80);
        for (int i = 0; i < 6; i++)
            add_pixel(ACT_PIXEL, (i % 2) ? 8'hFF : 8'h00, 8'(i * 40), 8'hFE);
        add_pixel(ACT_PIXEL, 8'h77, 8'h77, 8'h77);
        for (int i = 0; i < 4; i++) add_pixel(ACT_DRAIN, 8'h00, 8'h00, 8'h00);
        set_frame(1, 1);
        for (int i = 0; i < 4; i++) add_random_pixel();
        set_frame(3, 65535);
        for (int i = 0; i < 20; i++) add_random_pixel();
        set_frame(2047, 2);
        for (int i = 0; i < 1030; i++) add_random_pixel();
        set_frame(1024, 1);
        for (int i = 0; i < 30; i++) add_random_pixel();

        // Random frames under changing idling.
        phase = 0;
        while (phase < 5 || queued < 1200) begin
            w = ($urandom_range(7) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
            h = $urandom_range(6, 1);
            if (phase == 4) begin
                w = 16;
                h = 4;
            end
            set_frame(w, h);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            if (phase == 4) hold_go = 1'b1;
            add_frame(w, h);
            if ($urandom_range(1) == 0) add_frame(w, h);
            phase++;
        end

        wait_idle();
        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule

[median_filter_3x3_rgb.f]
rtl/mf3_pkg.sv
rtl/mf3_front.sv
rtl/mf3_queue.sv
rtl/mf3_back.sv
rtl/median_filter_3x3_rgb.sv
verif/median_filter_3x3_rgb_tb.sv
